// ----- sv/mhq_pkg.sv -----
// shared types and constants of the multilevel hysteresis quantizer
`default_nettype none
package mhq_pkg;

  // fixed field widths
  localparam int unsigned SAMPLE_W  = 10;
  localparam int unsigned SPACING_W = 10;
  localparam int unsigned MARGIN_W  = 9;
  localparam int unsigned LEVEL_W   = 5;

  // stream data widths (rounded up to whole bytes)
  localparam int unsigned S_DATA_W = 16;
  localparam int unsigned M_DATA_W = 8;

  // register file
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    REG_SPACING = 2'd0,
    REG_MARGIN  = 2'd1,
    REG_LEVELS  = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_e;

  localparam logic [SPACING_W-1:0] SPACING_RST = 10'd62;
  localparam logic [MARGIN_W-1:0]  MARGIN_RST  = 9'd6;
  localparam logic [LEVEL_W-1:0]   LEVELS_RST  = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_CMP  = 2'd1,
    ST_WALK = 2'd2
  } state_e;

  // per-threshold compare results of one cell
  typedef struct packed {
    logic up_ok;  // sample >= threshold + margin
    logic dn_ok;  // sample <= threshold - margin
  } flags_t;

endpackage
`default_nettype wire

// ----- sv/multilevel_hysteresis_quantizer_core.sv -----
// top level of the multilevel hysteresis quantizer: register file, cell row and level walker
// a new sample is accepted only in the idle state, so a further sample waits until the walker has
// moved the level, one level per cycle, and loaded the result into the output register
// the walker reads the compare flags that the threshold cell row refreshes every cycle
// reset clears level and last sample and sets the registers to their reset values;
// s_axis_tready_o stays low after reset and after any register write while the threshold chain refills
`default_nettype none
module multilevel_hysteresis_quantizer_core #(
  parameter int unsigned MAX_LEVELS  = 16,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input stream, tdata: sample[9:0], zero pad above
  input  wire logic [mhq_pkg::S_DATA_W-1:0]   s_axis_tdata_i,
  input  wire logic                           s_axis_tvalid_i,
  output      logic                           s_axis_tready_o,
  // output stream, tdata: level[4:0], zero pad above
  output      logic [mhq_pkg::M_DATA_W-1:0]   m_axis_tdata_o,
  output      logic                           m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // register port
  input  wire logic                           psel_i,
  input  wire logic                           penable_i,
  input  wire logic                           pwrite_i,
  input  wire logic [mhq_pkg::ADDR_W-1:0]     paddr_i,
  input  wire logic [mhq_pkg::DATA_W-1:0]     pwdata_i,
  output      logic [mhq_pkg::DATA_W-1:0]     prdata_o,
  output      logic                           pready_o
);

  // threshold width: wide enough for spacing times number of levels
  localparam int unsigned THR_W = mhq_pkg::SPACING_W + $clog2(MAX_LEVELS + 1);
  localparam int unsigned CNT_W = $clog2(MAX_LEVELS + 1);
  // bits of the sample field actually used
  localparam int unsigned USE_W = (SAMPLE_BITS < mhq_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                                     : mhq_pkg::SAMPLE_W;

  localparam logic [mhq_pkg::LEVEL_W-1:0] LEVEL_CAP =
    (MAX_LEVELS < 31) ? mhq_pkg::LEVEL_W'(MAX_LEVELS) : {mhq_pkg::LEVEL_W{1'b1}};

  // ---------------------------------------------------------------- registers
  logic [mhq_pkg::SPACING_W-1:0] spacing_q;
  logic [mhq_pkg::MARGIN_W-1:0]  margin_q;
  logic [mhq_pkg::LEVEL_W-1:0]   nlev_q;
  logic                          wr_en;
  mhq_pkg::reg_idx_e             wr_idx;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i & penable_i & pwrite_i & pready_o;
  // decode on the word index, low byte address bits ignored
  assign wr_idx   = mhq_pkg::reg_idx_e'(paddr_i[mhq_pkg::ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= mhq_pkg::SPACING_RST;
      margin_q  <= mhq_pkg::MARGIN_RST;
      nlev_q    <= mhq_pkg::LEVELS_RST;
    end else if (wr_en) begin
      case (wr_idx)
        mhq_pkg::REG_SPACING: spacing_q <= pwdata_i[mhq_pkg::SPACING_W-1:0];
        mhq_pkg::REG_MARGIN:  margin_q  <= pwdata_i[mhq_pkg::MARGIN_W-1:0];
        mhq_pkg::REG_LEVELS:  nlev_q    <= pwdata_i[mhq_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (wr_idx)
      mhq_pkg::REG_SPACING: prdata_o = mhq_pkg::DATA_W'(spacing_q);
      mhq_pkg::REG_MARGIN:  prdata_o = mhq_pkg::DATA_W'(margin_q);
      mhq_pkg::REG_LEVELS:  prdata_o = mhq_pkg::DATA_W'(nlev_q);
      default:              prdata_o = '0;
    endcase
  end

  // ---------------------------------------------------------------- settle counter
  // threshold k becomes valid once spacing has passed through the threshold registers of cells 0 to k
  logic [CNT_W-1:0] settle_q, settle_d;

  always_comb begin
    settle_d = settle_q;
    if (wr_en) begin
      settle_d = CNT_W'(MAX_LEVELS);
    end else if (settle_q != '0) begin
      settle_d = settle_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= CNT_W'(MAX_LEVELS);
    end else begin
      settle_q <= settle_d;
    end
  end

  // ---------------------------------------------------------------- cell row
  logic [mhq_pkg::SAMPLE_W-1:0]  sample_q;
  logic [THR_W-1:0]              thr   [MAX_LEVELS];
  mhq_pkg::flags_t               flags [MAX_LEVELS];
  logic [mhq_pkg::SPACING_W-1:0] first_step;

  // threshold 0 is spacing - floor(spacing/2), the rest step by spacing
  assign first_step = spacing_q - (spacing_q >> 1);

  for (genvar k = 0; k < MAX_LEVELS; k++) begin : g_cell
    if (k == 0) begin : g_head
      mhq_cell #(.THR_W(THR_W)) u_cell (
        .clk_i      (clk_i),
        .prev_thr_i ('0),
        .step_i     (first_step),
        .sample_i   (sample_q),
        .margin_i   (margin_q),
        .thr_o      (thr[k]),
        .flags_o    (flags[k])
      );
    end else begin : g_body
      mhq_cell #(.THR_W(THR_W)) u_cell (
        .clk_i      (clk_i),
        .prev_thr_i (thr[k-1]),
        .step_i     (spacing_q),
        .sample_i   (sample_q),
        .margin_i   (margin_q),
        .thr_o      (thr[k]),
        .flags_o    (flags[k])
      );
    end
  end

  // ---------------------------------------------------------------- level walker
  mhq_pkg::state_e              state_q, state_d;
  logic [mhq_pkg::LEVEL_W-1:0]  lvl_q, lvl_d;
  logic [mhq_pkg::SAMPLE_W-1:0] last_q;
  logic                         rising_q;
  logic [mhq_pkg::LEVEL_W-1:0]  out_q;
  logic                         out_vld_q, out_vld_d;
  logic                         out_load;
  logic [mhq_pkg::SAMPLE_W-1:0] s_in;
  logic                         in_xfer;
  logic [mhq_pkg::LEVEL_W-1:0]  n_eff;
  logic                         up_sel, dn_sel;
  logic                         step_up, step_dn;

  assign s_in    = mhq_pkg::SAMPLE_W'(s_axis_tdata_i[USE_W-1:0]);
  assign in_xfer = s_axis_tvalid_i & s_axis_tready_o;

  // levels in use clipped to the number of cells
  assign n_eff = (nlev_q > LEVEL_CAP) ? LEVEL_CAP : nlev_q;

  // flags of the threshold just above and just below the held level
  always_comb begin
    up_sel = 1'b0;
    dn_sel = 1'b0;
    for (int k = 0; k < MAX_LEVELS; k++) begin
      if (int'(lvl_q) == k) begin
        up_sel = flags[k].up_ok;
      end
      if (int'(lvl_q) == k + 1) begin
        dn_sel = flags[k].dn_ok;
      end
    end
  end

  assign step_up = rising_q  & (lvl_q < n_eff) & up_sel;
  assign step_dn = ~rising_q & (lvl_q != '0) & dn_sel;

  always_comb begin
    state_d         = state_q;
    lvl_d           = lvl_q;
    out_load        = 1'b0;
    s_axis_tready_o = 1'b0;
    case (state_q)
      mhq_pkg::ST_IDLE: begin
        s_axis_tready_o = (settle_q == '0);
        if (in_xfer) begin
          state_d = mhq_pkg::ST_CMP;
        end
      end
      mhq_pkg::ST_CMP: begin
        // cells register flags against the new sample
        state_d = mhq_pkg::ST_WALK;
      end
      mhq_pkg::ST_WALK: begin
        if (step_up) begin
          lvl_d = lvl_q + mhq_pkg::LEVEL_W'(1);
        end else if (step_dn) begin
          lvl_d = lvl_q - mhq_pkg::LEVEL_W'(1);
        end else if (!out_vld_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = mhq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mhq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mhq_pkg::ST_IDLE;
      lvl_q     <= '0;
      last_q    <= '0;
      rising_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      lvl_q     <= lvl_d;
      out_vld_q <= out_vld_d;
      if (in_xfer) begin
        // equal sample counts as rising
        rising_q <= (s_in >= last_q);
        last_q   <= s_in;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      sample_q <= s_in;
    end
    if (out_load) begin
      out_q <= lvl_q;
    end
  end

  assign m_axis_tdata_o  = mhq_pkg::M_DATA_W'(out_q);
  assign m_axis_tvalid_o = out_vld_q;

endmodule
`default_nettype wire

// ----- sv/mhq_cell.sv -----
// one threshold cell: builds its threshold from its neighbor and compares the sample
`default_nettype none
module mhq_cell #(
  parameter int unsigned THR_W = 15
) (
  input  wire logic                             clk_i,
  input  wire logic [THR_W-1:0]                 prev_thr_i,
  input  wire logic [mhq_pkg::SPACING_W-1:0]    step_i,
  input  wire logic [mhq_pkg::SAMPLE_W-1:0]     sample_i,
  input  wire logic [mhq_pkg::MARGIN_W-1:0]     margin_i,
  output      logic [THR_W-1:0]                 thr_o,
  output      mhq_pkg::flags_t                  flags_o
);

  logic [THR_W-1:0] thr_q, thr_d;
  mhq_pkg::flags_t  flags_q, flags_d;
  logic [THR_W:0]   upper_bound;
  logic [THR_W:0]   sample_ext;
  logic [THR_W:0]   sample_plus_m;

  always_comb begin
    thr_d         = prev_thr_i + THR_W'(step_i);
    upper_bound   = (THR_W+1)'(thr_q) + (THR_W+1)'(margin_i);
    sample_ext    = (THR_W+1)'(sample_i);
    sample_plus_m = sample_ext + (THR_W+1)'(margin_i);
    // lower bound test rewritten as sample + margin <= threshold, never negative
    flags_d.up_ok = sample_ext >= upper_bound;
    flags_d.dn_ok = sample_plus_m <= (THR_W+1)'(thr_q);
  end

  always_ff @(posedge clk_i) begin
    thr_q   <= thr_d;
    flags_q <= flags_d;
  end

  assign thr_o   = thr_q;
  assign flags_o = flags_q;

endmodule
`default_nettype wire

// ----- sim/multilevel_hysteresis_quantizer_core_tb.sv -----
// testbench of the multilevel hysteresis quantizer core: directed and random samples against a level predictor
`default_nettype none
module multilevel_hysteresis_quantizer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_LEVELS    = 16;
  localparam int unsigned SAMPLE_BITS   = 10;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned PHASE_ITEMS   = 100;
  localparam int          SAMPLE_MAX    = (1 << mhq_pkg::SAMPLE_W) - 1;

  logic                         clk     = 1'b0;
  logic                         rst_n   = 1'b0;
  logic [mhq_pkg::S_DATA_W-1:0] s_tdata  = '0;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [mhq_pkg::M_DATA_W-1:0] m_tdata;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic                         psel     = 1'b0;
  logic                         penable  = 1'b0;
  logic                         pwrite   = 1'b0;
  logic [mhq_pkg::ADDR_W-1:0]   paddr    = '0;
  logic [mhq_pkg::DATA_W-1:0]   pwdata   = '0;
  logic [mhq_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  multilevel_hysteresis_quantizer_core #(
    .MAX_LEVELS (MAX_LEVELS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tdata_i (s_tdata),   // sample[9:0], zero pad above
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .m_axis_tdata_o (m_tdata),   // level[4:0], zero pad above
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .prdata_o       (prdata),
    .pready_o       (pready)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state and its copy of the registers
  int unsigned cfg_spacing = mhq_pkg::SPACING_RST;
  int unsigned cfg_margin  = mhq_pkg::MARGIN_RST;
  int unsigned cfg_levels  = mhq_pkg::LEVELS_RST;
  int unsigned held_level  = 0;
  int unsigned prev_sample = 0;

  logic [mhq_pkg::LEVEL_W-1:0] expected_levels[$];
  int                          fails      = 0;
  int                          burst_left = 0;

  // threshold k sits at spacing*(k+1) - floor(spacing/2), signed
  function automatic int threshold(input int unsigned k);
    return int'(cfg_spacing) * int'(k + 1) - int'(cfg_spacing / 2);
  endfunction

  // walks the held level for one sample, one threshold at a time
  function automatic logic [mhq_pkg::LEVEL_W-1:0] quantize_sample(
    input logic [mhq_pkg::SAMPLE_W-1:0] smp);
    int unsigned s;
    int          n;
    s = int'(smp) & ((1 << SAMPLE_BITS) - 1);
    n = (cfg_levels > MAX_LEVELS) ? MAX_LEVELS : cfg_levels;
    // an equal sample counts as rising
    if (s >= prev_sample) begin
      while (int'(held_level) < n && int'(s) >= threshold(held_level) + int'(cfg_margin))
        held_level++;
    end else begin
      // bounds below zero are never met since the compare is signed
      while (held_level > 0 && int'(s) <= threshold(held_level - 1) - int'(cfg_margin))
        held_level--;
    end
    prev_sample = s;
    return held_level[mhq_pkg::LEVEL_W-1:0];
  endfunction

  // one sample transfer; bursts of random length separated by random gaps
  task automatic send_sample(input int unsigned value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    expected_levels.push_back(quantize_sample(value[mhq_pkg::SAMPLE_W-1:0]));
    s_tdata  <= {{(mhq_pkg::S_DATA_W-mhq_pkg::SAMPLE_W){1'b0}},
                 value[mhq_pkg::SAMPLE_W-1:0]};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // drop valid and wait for every outstanding level
  task automatic drain;
    s_tvalid   <= 1'b0;
    burst_left = 0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write followed by a readback; only the low register bits count
  task automatic write_reg(input mhq_pkg::reg_idx_e idx,
                           input logic [mhq_pkg::DATA_W-1:0] value);
    logic [mhq_pkg::DATA_W-1:0] mask;
    logic [mhq_pkg::DATA_W-1:0] wdata;
    case (idx)
      mhq_pkg::REG_SPACING: mask = (1 << mhq_pkg::SPACING_W) - 1;
      mhq_pkg::REG_MARGIN:  mask = (1 << mhq_pkg::MARGIN_W) - 1;
      default:              mask = (1 << mhq_pkg::LEVEL_W) - 1;
    endcase
    // junk in the unused upper bits half of the time
    wdata = ($urandom_range(0, 1) == 1) ? ((value & mask) | ($urandom() & ~mask)) : (value & mask);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= mhq_pkg::ADDR_W'(4 * int'(idx));
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      mhq_pkg::REG_SPACING: cfg_spacing = wdata & mask;
      mhq_pkg::REG_MARGIN:  cfg_margin  = wdata & mask;
      default:              cfg_levels  = wdata & mask;
    endcase
    // readback access
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) !== (wdata & mask)) begin
      $error("register %s: expected %0d, actual %0d", idx.name(), wdata & mask, prdata & mask);
      fails++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int unsigned sp, input int unsigned mg, input int unsigned lv);
    write_reg(mhq_pkg::REG_SPACING, sp);
    write_reg(mhq_pkg::REG_MARGIN, mg);
    write_reg(mhq_pkg::REG_LEVELS, lv);
  endtask

  // full climb from zero and full fall back under the reset settings
  task automatic test_reset_walk;
    send_sample(0);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(0);
    drain();
  endtask

  // an equal sample counts as rising and does not fall
  task automatic test_equal_sample;
    send_sample(40);
    send_sample(40);
    send_sample(30);
    send_sample(30);
    drain();
  endtask

  // zero levels never climb, too many levels stop at the maximum
  task automatic test_level_count;
    set_config(62, 6, 0);
    send_sample(SAMPLE_MAX);
    send_sample(500);
    drain();
    set_config(1, 0, 31);
    send_sample(SAMPLE_MAX);
    send_sample(0);
    drain();
    set_config(1023, 511, 1);
    send_sample(SAMPLE_MAX);
    send_sample(0);
    drain();
  endtask

  // zero spacing puts every threshold at zero
  task automatic test_zero_spacing;
    set_config(0, 0, 16);
    send_sample(0);
    send_sample(5);
    send_sample(0);
    drain();
    write_reg(mhq_pkg::REG_MARGIN, 511);
    send_sample(SAMPLE_MAX);
    drain();
  endtask

  // held level above a lowered level count: no climb, but it can fall
  task automatic test_level_above_count;
    set_config(62, 6, 16);
    send_sample(SAMPLE_MAX);
    drain();
    write_reg(mhq_pkg::REG_LEVELS, 4);
    send_sample(SAMPLE_MAX);
    send_sample(900);
    send_sample(1000);
    send_sample(10);
    drain();
  endtask

  // mostly a random walk so the level wanders through the thresholds
  function automatic int unsigned next_sample;
    int v;
    case ($urandom_range(0, 9))
      0:       v = $urandom_range(0, SAMPLE_MAX);
      1:       v = ($urandom_range(0, 1) == 1) ? SAMPLE_MAX : 0;
      2:       v = prev_sample;
      default: v = int'(prev_sample) + $urandom_range(0, 160) - 80;
    endcase
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return v;
  endfunction

  // random settings per phase, extremes included
  task automatic test_random;
    int unsigned sp;
    int unsigned mg;
    int unsigned lv;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 7))
        0:       sp = 0;
        1:       sp = 1;
        2:       sp = 1023;
        3:       sp = $urandom_range(1, 1023);
        default: sp = $urandom_range(20, 130);
      endcase
      case ($urandom_range(0, 4))
        0:       mg = 0;
        1:       mg = 511;
        default: mg = $urandom_range(0, (sp / 2 + 1 > 511) ? 511 : sp / 2 + 1);
      endcase
      case ($urandom_range(0, 9))
        0:       lv = 0;
        1:       lv = 1;
        2:       lv = 31;
        3:       lv = 17;
        4:       lv = 16;
        default: lv = $urandom_range(2, 16);
      endcase
      set_config(sp, mg, lv);
      repeat (PHASE_ITEMS) send_sample(next_sample());
      drain();
    end
  endtask

  // receiver stall pattern: a new mode every so often
  int unsigned rx_mode = 0;
  int unsigned rx_cnt  = 0;
  always @(posedge clk) begin
    if (rx_cnt % 150 == 0) begin
      rx_mode <= $urandom_range(0, 3);
    end
    rx_cnt <= rx_cnt + 1;
    case (rx_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= 1'($urandom_range(0, 1));
      2:       m_tready <= (rx_cnt % 8) < 5;
      default: m_tready <= (rx_cnt % 24) >= 18;
    endcase
  end

  // result check against the oldest expected level
  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) begin
      if (expected_levels.size() == 0) begin
        $error("level: expected none, actual %0d", m_tdata[mhq_pkg::LEVEL_W-1:0]);
        fails++;
      end else begin
        logic [mhq_pkg::LEVEL_W-1:0] exp_level;
        exp_level = expected_levels.pop_front();
        if (m_tdata[mhq_pkg::LEVEL_W-1:0] !== exp_level) begin
          $error("level: expected %0d, actual %0d", exp_level,
                 m_tdata[mhq_pkg::LEVEL_W-1:0]);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** multilevel_hysteresis_quantizer_core: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_walk();
    test_equal_sample();
    test_level_count();
    test_zero_spacing();
    test_level_above_count();
    test_random();
    // latency of a full walk plus margin
    repeat (40) @(posedge clk);
    if (fails == 0 && expected_levels.size() == 0) begin
      $display("** multilevel_hysteresis_quantizer_core: PASSED **");
    end else begin
      $display("** multilevel_hysteresis_quantizer_core: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
